/* sv/velocity_ramp_with_braking_assert.svh */
// Assertion macros used by the velocity ramp controller RTL.
`ifndef VELOCITY_RAMP_WITH_BRAKING_ASSERT_SVH
`define VELOCITY_RAMP_WITH_BRAKING_ASSERT_SVH
`ifndef SYNTHESIS
`define VRB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VRB_ASSERT_SAME(label, ante, cons)
`define VRB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/vrb_pkg.sv */
// Package: item types, kind codes, controller states and commands for the ramp.
`default_nettype none
package vrb_pkg;

    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_SET_GOAL  = 3'd1;
    localparam logic [2:0] KIND_OVERWRITE = 3'd2;
    localparam logic [2:0] KIND_LIMIT     = 3'd3;
    localparam logic [2:0] KIND_QUERY     = 3'd4;

    localparam logic [30:0] SAT31      = 31'h7FFF_FFFF;
    localparam logic [30:0] ACCEL_RST  = 31'd65536;
    localparam logic [5:0]  SQRT_STEPS = 6'd32;
    localparam logic [5:0]  DIV_STEPS  = 6'd31;

    typedef struct packed {
        logic [2:0]   kind;
        logic [15:0]  interval;
        logic signed [31:0] speed_in;
        logic [30:0]  distance;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] current_speed;
        logic signed [31:0] target_speed;
        logic               complete;
        logic [30:0]        braking_distance;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL_A, ST_MUL_B, ST_PREP, ST_ITER, ST_WB
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE, OP_LOAD, OP_MUL_A, OP_MUL_B, OP_PREP, OP_ITER, OP_WB
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       iter_last;
        logic       div_sat;
        logic       out_free;
    } t_status;

endpackage
`default_nettype wire

/* sv/velocity_ramp_with_braking.sv */
// Sequence per item: tick, set target, overwrite and unknown kinds run a multiply, then
// write-back; a distance limit runs a multiply and a 32-step square root, then write-back;
// a query runs two squarings on the shared multiplier and a 31-step divider (skipped when saturated).
// One item at a time: the next is taken only back in idle, after write-back; a result held
// by the receiver holds write-back and with it the input.
// Reset (synchronous, active low): speed 0, target 0, complete 1, max_accel 1.0.
`default_nettype none
module velocity_ramp_with_braking (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire vrb_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output vrb_pkg::t_out_item      o_out_item,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import vrb_pkg::*;

    logic [30:0] r_accel;
    t_cmd        cmd;
    t_status     status;

    // Register file: max_accel at byte addresses 0 to 3 (paddr[2] low); addresses 4 to 7 drop writes and read 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel <= ACCEL_RST;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_accel <= pwdata[30:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {1'b0, r_accel};

    vrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    vrb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_accel     (r_accel),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

/* sv/vrb_ctrl.sv */
// Controller: sequences one item through multiply, iterate and write-back.
`default_nettype none
`include "velocity_ramp_with_braking_assert.svh"
module vrb_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire vrb_pkg::t_status i_status,
    output vrb_pkg::t_cmd        o_cmd
);
    import vrb_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                o_cmd.op = OP_MUL_A;
                case (i_status.kind)
                    KIND_QUERY: n_state = ST_MUL_B;
                    KIND_LIMIT: n_state = ST_PREP;
                    default:    n_state = ST_WB;
                endcase
            end
            ST_MUL_B: begin
                o_cmd.op = OP_MUL_B;
                n_state  = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.op = OP_PREP;
                if (i_status.kind == KIND_QUERY && i_status.div_sat) begin
                    n_state = ST_WB;
                end else begin
                    n_state = ST_ITER;
                end
            end
            ST_ITER: begin
                o_cmd.op = OP_ITER;
                if (i_status.iter_last) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_WB;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `VRB_ASSERT_NEXT(a_accept_starts, r_state == ST_IDLE && i_in_valid, r_state == ST_MUL_A)
    `VRB_ASSERT_NEXT(a_iter_exit, r_state == ST_ITER && i_status.iter_last, r_state == ST_WB)
    `VRB_ASSERT_SAME(a_wb_needs_room, o_cmd.op == OP_WB, i_status.out_free)

endmodule
`default_nettype wire

/* sv/vrb_dp.sv */
// Datapath: ramp state, shared multiplier, square root and divider steps.
`default_nettype none
module vrb_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vrb_pkg::t_cmd     i_cmd,
    output vrb_pkg::t_status       o_status,
    input  wire logic [30:0]       i_accel,
    input  wire vrb_pkg::t_in_item i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output vrb_pkg::t_out_item     o_out_item
);
    import vrb_pkg::*;

    t_in_item r_item;
    logic signed [31:0] r_now, r_goal;
    logic               r_reached;
    logic [63:0]        r_prod_a, r_prod_b, r_x;
    logic [34:0]        r_rem;
    logic [31:0]        r_root;
    logic [5:0]         r_cnt;
    logic               r_sat;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [31:0] mul_l, mul_r, mag_in, mag_now, div;
    logic [63:0] product, diff;
    logic        div_sat;
    logic [34:0] sq_sh, sq_trial;
    logic [32:0] dv_sh;
    logic [30:0] step;
    logic signed [32:0] gap, agap;
    logic signed [31:0] lim;
    logic signed [31:0] n_now, n_goal;
    logic               n_reached;

    assign mag_in  = r_item.speed_in[31] ? 32'(-r_item.speed_in) : r_item.speed_in;
    assign mag_now = r_now[31] ? 32'(-r_now) : r_now;
    assign div     = {i_accel, 1'b0};

    always_comb begin
        mul_l = {1'b0, i_accel};
        mul_r = {16'd0, r_item.interval};
        if (i_cmd.op == OP_MUL_B) begin
            mul_l = mag_now;
            mul_r = mag_now;
        end else if (r_item.kind == KIND_QUERY) begin
            mul_l = mag_in;
            mul_r = mag_in;
        end else if (r_item.kind == KIND_LIMIT) begin
            mul_r = {1'b0, r_item.distance};
        end
    end
    assign product = mul_l * mul_r;

    assign diff    = (r_prod_a >= r_prod_b) ? r_prod_a - r_prod_b : r_prod_b - r_prod_a;
    assign div_sat = (i_accel == '0) || (diff[63:31] >= {1'b0, div});

    assign sq_sh    = {r_rem[32:0], r_x[63:62]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign dv_sh    = {r_rem[31:0], r_x[63]};

    // Ramp and goal update at write-back.
    assign step = r_prod_a[46:16];
    assign gap  = 33'(r_goal) - 33'(r_now);
    assign agap = gap[32] ? -gap : gap;
    assign lim  = r_root[31] ? {1'b0, SAT31} : r_root;

    always_comb begin
        n_now     = r_now;
        n_goal    = r_goal;
        n_reached = r_reached;
        case (r_item.kind)
            KIND_TICK: begin
                if (!r_reached) begin
                    if (agap < $signed({2'b0, step})) begin
                        n_now     = r_goal;
                        n_reached = 1'b1;
                    end else if (gap > 0) begin
                        n_now = 32'(r_now + $signed({1'b0, step}));
                    end else if (gap < 0) begin
                        n_now = 32'(r_now - $signed({1'b0, step}));
                    end
                end
            end
            KIND_SET_GOAL: begin
                if (r_item.speed_in != r_goal) begin
                    n_goal    = r_item.speed_in;
                    n_reached = 1'b0;
                end
            end
            KIND_OVERWRITE: begin
                if (r_item.speed_in != r_now) begin
                    n_now     = r_item.speed_in;
                    n_reached = 1'b0;
                end
            end
            KIND_LIMIT: begin
                if (lim < r_goal) begin
                    n_goal    = lim;
                    n_reached = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= '0;
            r_goal      <= '0;
            r_reached   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op == OP_WB) begin
                r_now       <= n_now;
                r_goal      <= n_goal;
                r_reached   <= n_reached;
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD:  r_item   <= i_in_item;
            OP_MUL_A: r_prod_a <= product;
            OP_MUL_B: r_prod_b <= product;
            OP_PREP: begin
                r_root <= '0;
                r_sat  <= div_sat;
                if (r_item.kind == KIND_LIMIT) begin
                    r_x   <= {1'b0, r_prod_a[61:0], 1'b0};
                    r_rem <= '0;
                    r_cnt <= SQRT_STEPS;
                end else begin
                    r_x   <= {diff[30:0], 33'd0};
                    r_rem <= {2'b0, diff[63:31]};
                    r_cnt <= DIV_STEPS;
                end
            end
            OP_ITER: begin
                r_cnt <= r_cnt - 6'd1;
                if (r_item.kind == KIND_LIMIT) begin
                    r_x <= {r_x[61:0], 2'b00};
                    if (sq_sh >= sq_trial) begin
                        r_rem  <= sq_sh - sq_trial;
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= sq_sh;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                end else begin
                    r_x <= {r_x[62:0], 1'b0};
                    if (dv_sh >= {1'b0, div}) begin
                        r_rem  <= {2'b0, 33'(dv_sh - {1'b0, div})};
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= {2'b0, dv_sh};
                        r_root <= {r_root[30:0], 1'b0};
                    end
                end
            end
            OP_WB: begin
                r_out.current_speed    <= n_now;
                r_out.target_speed     <= n_goal;
                r_out.complete         <= n_reached;
                r_out.braking_distance <= (r_item.kind != KIND_QUERY) ? 31'd0 :
                                          (r_sat ? SAT31 : r_root[30:0]);
            end
            default: ;
        endcase
    end

    assign o_status.kind      = r_item.kind;
    assign o_status.iter_last = (r_cnt == 6'd1);
    assign o_status.div_sat   = div_sat;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;

endmodule
`default_nettype wire
